### design/eh_ptr_pkg.sv
// Shared types and constants for the exception-frame pointer decoder.
package eh_ptr_pkg;

   // Input beat: one byte of frame data plus the per-pointer header fields.
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first;
      logic [7:0]  encoding;
      logic [63:0] pc_base;
      logic [2:0]  byte_pos;
   } req_type;

   // Result beat: one decoded pointer.
   typedef struct packed {
      logic [63:0] value;
      logic [3:0]  bytes_read;
      logic [2:0]  pad_bytes;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_OMIT     = 2'd1,
      ST_INVALID  = 2'd2,
      ST_OVERFLOW = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CSR_TEXT_BASE  = 2'd0,
      CSR_DATA_BASE  = 2'd1,
      CSR_FUNC_BASE  = 2'd2,
      CSR_ALIGN_LOG2 = 2'd3
   } csr_index_type;

   // Configuration registers as seen by the decode core.
   typedef struct packed {
      logic [63:0] text_base;
      logic [63:0] data_base;
      logic [63:0] func_base;
      logic [1:0]  align_log2;
   } cfg_type;

   // Result produced by the core for the beat it consumed.
   typedef struct packed {
      logic    valid;
      rsp_type rsp;
   } core_res_type;

   localparam logic [7:0] ENC_OMIT    = 8'hFF;
   localparam logic [6:0] ENC_ALIGNED = 7'h50;

   // Low nibble of the encoding: value format.
   localparam logic [3:0] TYPE_ULEB = 4'h1;
   localparam logic [3:0] TYPE_SLEB = 4'h9;

   // Low three bits of a fixed-size type that select 2 or 4 bytes.
   localparam logic [2:0] FIX_2 = 3'd2;
   localparam logic [2:0] FIX_4 = 3'd3;

   // Bits 6..4 of the encoding: which base is added.
   localparam logic [2:0] MOD_ABS  = 3'd0;
   localparam logic [2:0] MOD_PC   = 3'd1;
   localparam logic [2:0] MOD_TEXT = 3'd2;
   localparam logic [2:0] MOD_DATA = 3'd3;
   localparam logic [2:0] MOD_FUNC = 3'd4;

   localparam int LEB_DIGIT_BITS = 7;

endpackage

### design/eh_pointer_decoder.sv
// Top level of the byte-serial exception-frame pointer decoder.
//
//   Channel  Ports                           Direction  Moves
//   req      req_valid req_stall req_data    in         one frame byte and pointer header
//   rsp      rsp_valid rsp_stall rsp_data    out        one decoded pointer
//   csr      csr_wr_en csr_index csr_wdata   in         base and alignment register writes
//
// Each byte beat is registered on entry and then decoded, so a beat can be taken in every
// cycle unless req is stalled. A pointer's result is registered in the result register.
// The decode stage runs the shift-or into the accumulator and the final 64-bit base add.
// Reset is synchronous and returns the control and CSR registers to their reset values,
// with align_log2 at three; stage data registers are not reset. A stall on rsp holds the
// decode stage only while the result register is full, and that in turn stalls req.
module eh_pointer_decoder import eh_ptr_pkg::*; #(
   parameter int MAX_LEB_BYTES = 10
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,

   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   // Configuration registers. Writes must arrive only while the decoder is idle; not enforced.
   logic [63:0] text_base_ff;
   logic [63:0] data_base_ff;
   logic [63:0] func_base_ff;
   logic [1:0]  align_log2_ff;
   cfg_type     cfg;

   logic         item_valid;
   req_type      item;
   logic         out_full;
   logic         fire;
   core_res_type res;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_base_ff  <= '0;
         data_base_ff  <= '0;
         func_base_ff  <= '0;
         align_log2_ff <= 2'd3;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TEXT_BASE:  text_base_ff  <= csr_wdata;
            CSR_DATA_BASE:  data_base_ff  <= csr_wdata;
            CSR_FUNC_BASE:  func_base_ff  <= csr_wdata;
            CSR_ALIGN_LOG2: align_log2_ff <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   assign cfg.text_base  = text_base_ff;
   assign cfg.data_base  = data_base_ff;
   assign cfg.func_base  = func_base_ff;
   assign cfg.align_log2 = align_log2_ff;

   // The decode stage consumes its held byte whenever the result register can take
   // whatever that byte produces.
   assign fire = item_valid && !out_full;

   eh_ptr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .advance    (fire),
      .item_valid (item_valid),
      .item       (item)
   );

   eh_ptr_core #(
      .MAX_LEB_BYTES (MAX_LEB_BYTES)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .item  (item),
      .cfg   (cfg),
      .res   (res)
   );

   eh_ptr_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .res       (res),
      .full      (out_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### design/eh_ptr_in_stage.sv
// Input register stage of the pointer decoder.
module eh_ptr_in_stage import eh_ptr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    advance,
   output logic    item_valid,
   output req_type item
);

   logic    valid_ff, valid_in;
   req_type data_ff, data_in;
   logic    accept;

   assign req_stall  = valid_ff && !advance;
   assign accept     = req_valid && !req_stall;
   assign item_valid = valid_ff;
   assign item       = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (accept) begin
         valid_in = 1'b1;
         data_in  = req_data;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

### design/eh_ptr_core.sv
// Decode state and per-byte decode logic of the pointer decoder.
module eh_ptr_core import eh_ptr_pkg::*; #(
   parameter int MAX_LEB_BYTES = 10
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  req_type      item,
   input  cfg_type      cfg,
   output core_res_type res
);

   localparam int CNT_W = $clog2(MAX_LEB_BYTES + 1);
   localparam int SH_W  = $clog2(LEB_DIGIT_BITS * MAX_LEB_BYTES + 1);

   logic             busy_ff, busy_in;
   logic [6:0]       enc_ff, enc_in;
   logic [63:0]      pc_ff, pc_in;
   logic [63:0]      acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [2:0]       padl_ff, padl_in;
   logic [2:0]       padc_ff, padc_in;

   logic [6:0]       e;
   logic             enc_ok;
   logic [2:0]       align_mask;
   logic [2:0]       pad_first;
   logic [3:0]       t;
   logic [SH_W-1:0]  leb_sh;
   logic [SH_W-1:0]  leb_sh_next;
   logic [3:0]       fsize;
   logic             done;
   logic [63:0]      base;

   assign e          = item.encoding[6:0];
   assign enc_ok     = (e == ENC_ALIGNED) ||
                       ((e[6:4] <= MOD_FUNC) && (e[3:0] inside {[4'd0:4'd4], [4'd8:4'd12]}));
   assign align_mask = 3'((4'd1 << cfg.align_log2) - 4'd1);
   assign pad_first  = (3'd0 - item.byte_pos) & align_mask;

   always_comb begin
      res         = '0;
      busy_in     = busy_ff;
      enc_in      = enc_ff;
      pc_in       = pc_ff;
      acc_in      = acc_ff;
      cnt_in      = cnt_ff;
      padl_in     = padl_ff;
      padc_in     = padc_ff;
      t           = '0;
      leb_sh      = '0;
      leb_sh_next = '0;
      fsize       = '0;
      done        = 1'b0;
      base        = '0;

      // A first byte resolves omit and bad encodings at once, else loads the header.
      if (item.first) begin
         busy_in = 1'b0;
         if (item.encoding == ENC_OMIT) begin
            res.valid      = 1'b1;
            res.rsp.status = ST_OMIT;
         end else if (!enc_ok) begin
            res.valid      = 1'b1;
            res.rsp.status = ST_INVALID;
         end else begin
            busy_in = 1'b1;
            pc_in   = item.pc_base;
            acc_in  = '0;
            cnt_in  = '0;
            padc_in = '0;
            if (e == ENC_ALIGNED) begin
               enc_in  = '0;
               padl_in = pad_first;
            end else begin
               enc_in  = e;
               padl_in = '0;
            end
         end
      end

      if (busy_in) begin
         if (padl_in != 3'd0) begin
            padl_in = padl_in - 3'd1;
            padc_in = padc_in + 3'd1;
         end else begin
            t = enc_in[3:0];
            if ((t == TYPE_ULEB) || (t == TYPE_SLEB)) begin
               leb_sh = SH_W'(cnt_in) * SH_W'(LEB_DIGIT_BITS);
               if (leb_sh < SH_W'(64)) begin
                  acc_in = acc_in | (64'(item.data_byte[6:0]) << leb_sh);
               end
               cnt_in = cnt_in + CNT_W'(1);
               if (item.data_byte[7]) begin
                  if (cnt_in >= CNT_W'(MAX_LEB_BYTES)) begin
                     busy_in            = 1'b0;
                     res.valid          = 1'b1;
                     res.rsp.value      = '0;
                     res.rsp.bytes_read = 4'(cnt_in);
                     res.rsp.pad_bytes  = '0;
                     res.rsp.status     = ST_OVERFLOW;
                  end
               end else begin
                  leb_sh_next = SH_W'(cnt_in) * SH_W'(LEB_DIGIT_BITS);
                  if ((t == TYPE_SLEB) && item.data_byte[6] && (leb_sh_next < SH_W'(64))) begin
                     acc_in = acc_in | (~64'd0 << leb_sh_next);
                  end
                  done = 1'b1;
               end
            end else begin
               case (t[2:0])
                  FIX_2:   fsize = 4'd2;
                  FIX_4:   fsize = 4'd4;
                  default: fsize = 4'd8;
               endcase
               acc_in = acc_in | (64'(item.data_byte) << {cnt_in[2:0], 3'b000});
               cnt_in = cnt_in + CNT_W'(1);
               if (cnt_in >= CNT_W'(fsize)) begin
                  done = 1'b1;
                  if (t[3]) begin
                     if ((fsize == 4'd2) && acc_in[15]) begin
                        acc_in[63:16] = '1;
                     end else if ((fsize == 4'd4) && acc_in[31]) begin
                        acc_in[63:32] = '1;
                     end
                  end
               end
            end

            if (done) begin
               case (enc_in[6:4])
                  MOD_PC:   base = pc_in;
                  MOD_TEXT: base = cfg.text_base;
                  MOD_DATA: base = cfg.data_base;
                  MOD_FUNC: base = cfg.func_base;
                  default:  base = '0;
               endcase
               busy_in            = 1'b0;
               res.valid          = 1'b1;
               res.rsp.value      = base + acc_in;
               res.rsp.bytes_read = 4'(cnt_in);
               res.rsp.pad_bytes  = padc_in;
               res.rsp.status     = ST_OK;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         enc_ff  <= '0;
         pc_ff   <= '0;
         acc_ff  <= '0;
         cnt_ff  <= '0;
         padl_ff <= '0;
         padc_ff <= '0;
      end else if (fire) begin
         busy_ff <= busy_in;
         enc_ff  <= enc_in;
         pc_ff   <= pc_in;
         acc_ff  <= acc_in;
         cnt_ff  <= cnt_in;
         padl_ff <= padl_in;
         padc_ff <= padc_in;
      end
   end

endmodule

### design/eh_ptr_out_stage.sv
// Result register stage of the pointer decoder.
module eh_ptr_out_stage import eh_ptr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  core_res_type res,
   output logic         full,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_type      rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign full      = valid_ff && rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (fire && res.valid) begin
         valid_in = 1'b1;
         data_in  = res.rsp;
      end else if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule
